// ===== src/dts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg: shared definitions for the deadline timer scheduler
// Operation and result codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package dts_pkg;

	localparam int NUM_SLOTS_DEF     = 16;
	localparam int INTERVAL_BITS_DEF = 16;
	localparam int TIME_BITS_DEF     = 32;

	localparam int MAX_FIRES     = 16;
	localparam int FIRE_CNT_BITS = $clog2(MAX_FIRES + 1);

	localparam int OP_BITS    = 3;
	localparam int IDX_BITS   = 4;
	localparam int IVAL_W     = 16;
	localparam int KIND_BITS  = 3;
	localparam int SLOT_BITS  = 4;

	typedef enum logic [OP_BITS-1:0] {
		OP_TICK   = 3'd0,
		OP_ADD    = 3'd1,
		OP_CANCEL = 3'd2,
		OP_PAUSE  = 3'd3,
		OP_RESUME = 3'd4
	} op_t;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_NONE  = 3'd0,
		KIND_ADDED = 3'd1,
		KIND_FULL  = 3'd2,
		KIND_FIRED = 3'd3,
		KIND_ACK   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_TICK_INC,
		ST_SCAN,
		ST_BEST_RD,
		ST_BEST_WB,
		ST_PUSH,
		ST_FINAL
	} state_t;

endpackage

// ===== src/dts_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_slot_mem: slot storage
// One write port and one registered read port holding periodic mark,
// interval and deadline of every slot.
// ----------------------------------------------------------------------------
module dts_slot_mem #(
	parameter int DEPTH = dts_pkg::NUM_SLOTS_DEF,
	parameter int WIDTH = 1 + dts_pkg::INTERVAL_BITS_DEF + dts_pkg::TIME_BITS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/dts_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_alu: shared time adder
// Adds to or subtracts from the current time, modulo the time width.
// ----------------------------------------------------------------------------
module dts_alu #(
	parameter int W = dts_pkg::TIME_BITS_DEF
) (
	input  logic         sub,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] res
);

	logic [W-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign res   = a + b_eff + W'(sub);

endmodule

// ===== src/deadline_timer_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_scheduler: table of one-shot and periodic timer slots
// Adds, cancels and fires timer slots in deadline order on every tick that is not paused.
// ----------------------------------------------------------------------------
// Every firing of a tick is chosen by a full pass over the slot memory through
// its single read port, with one shared adder forming the lateness of each slot,
// and a last pass finds nothing more due; that last pass is left out once
// MAX_FIRES slots have fired, and a paused tick makes no pass. Output stalls
// hold the scheduler. The input stalls until each word has been handled.
module deadline_timer_scheduler #(
	parameter int NUM_SLOTS     = dts_pkg::NUM_SLOTS_DEF,
	parameter int INTERVAL_BITS = dts_pkg::INTERVAL_BITS_DEF,
	parameter int TIME_BITS     = dts_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [dts_pkg::OP_BITS-1:0]     operation,
	input  logic [dts_pkg::IDX_BITS-1:0]    slot_index,
	input  logic [dts_pkg::IVAL_W-1:0]      interval,
	input  logic                            periodic,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [dts_pkg::KIND_BITS-1:0]   kind,
	output logic [dts_pkg::SLOT_BITS-1:0]   slot,
	output logic                            last
);

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int TB = TIME_BITS;
	localparam int IB = INTERVAL_BITS;
	localparam int MW = 1 + IB + TB;
	localparam int FCW = dts_pkg::FIRE_CNT_BITS;
	localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

	dts_pkg::state_t state_q, state_n;

	logic [TB-1:0]        now_q;
	logic                 paused_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] fired_q;

	logic [SW-1:0] op_slot_q;
	logic [IB-1:0] op_ival_q;
	logic          op_per_q;

	logic          issue_q;
	logic [SW-1:0] scan_q;
	logic          v_s1;
	logic [SW-1:0] slot_s1;
	logic          last_s1;
	logic          v_s2;
	logic [SW-1:0] slot_s2;
	logic          last_s2;
	logic          elig_s2;
	logic [TB-1:0] late_s2;

	logic          best_v_q;
	logic [SW-1:0] best_slot_q;
	logic [TB-1:0] best_late_q;
	logic          pend_v_q;
	logic [SW-1:0] pend_slot_q;
	logic [FCW-1:0] cnt_q;

	logic                  out_valid_q;
	dts_pkg::kind_t        kind_q;
	logic [dts_pkg::SLOT_BITS-1:0] slot_q;
	logic                  last_q;

	logic          accept;
	logic          out_free;
	logic          free_v;
	logic [SW-1:0] free_idx;
	logic          cancel_ok;
	logic [IB-1:0] in_ival;

	logic          upd;
	logic          scan_done;
	logic          best_v_n;
	logic          push_go;
	logic          final_cnt;

	logic          alu_sub;
	logic [TB-1:0] alu_b;
	logic [TB-1:0] alu_res;

	logic          mem_we;
	logic [SW-1:0] mem_waddr;
	logic [MW-1:0] mem_wdata;
	logic [SW-1:0] mem_raddr;
	logic [MW-1:0] mem_rdata;
	logic [TB-1:0] rd_deadline;
	logic [IB-1:0] rd_ival;
	logic          rd_per;

	logic                  out_load;
	dts_pkg::kind_t        out_kind_n;
	logic [dts_pkg::SLOT_BITS-1:0] out_slot_n;
	logic                  out_last_n;
	logic                  scan_start;

	dts_slot_mem #(
		.DEPTH (NUM_SLOTS),
		.WIDTH (MW),
		.AW    (SW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dts_alu #(
		.W (TB)
	) u_alu (
		.sub (alu_sub),
		.a   (now_q),
		.b   (alu_b),
		.res (alu_res)
	);

	assign rd_deadline = mem_rdata[TB-1:0];
	assign rd_ival     = mem_rdata[TB+IB-1:TB];
	assign rd_per      = mem_rdata[TB+IB];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != dts_pkg::ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign in_ival  = IB'(interval);
	assign cancel_ok = 32'(slot_index) < 32'(NUM_SLOTS);

	always_comb begin
		free_v   = 1'b0;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_v   = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign upd       = v_s2 && elig_s2 && (!best_v_q || (late_s2 > best_late_q));
	assign scan_done = v_s2 && last_s2;
	assign best_v_n  = best_v_q || upd;
	assign push_go   = !pend_v_q || out_free;
	assign final_cnt = cnt_q == FCW'(dts_pkg::MAX_FIRES - 1);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			dts_pkg::ST_IDLE: begin
				if (accept && operation == dts_pkg::OP_TICK) begin
					state_n = dts_pkg::ST_TICK_INC;
				end else if (accept && operation == dts_pkg::OP_ADD && free_v) begin
					state_n = dts_pkg::ST_ADD_WR;
				end
			end
			dts_pkg::ST_ADD_WR: state_n = dts_pkg::ST_IDLE;
			dts_pkg::ST_TICK_INC: begin
				state_n = paused_q ? dts_pkg::ST_FINAL : dts_pkg::ST_SCAN;
			end
			dts_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_n = best_v_n ? dts_pkg::ST_BEST_RD : dts_pkg::ST_FINAL;
				end
			end
			dts_pkg::ST_BEST_RD: state_n = dts_pkg::ST_BEST_WB;
			dts_pkg::ST_BEST_WB: state_n = dts_pkg::ST_PUSH;
			dts_pkg::ST_PUSH: begin
				if (push_go) begin
					state_n = final_cnt ? dts_pkg::ST_FINAL : dts_pkg::ST_SCAN;
				end
			end
			dts_pkg::ST_FINAL: begin
				if (out_free) begin
					state_n = dts_pkg::ST_IDLE;
				end
			end
			default: state_n = dts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		alu_sub    = 1'b0;
		alu_b      = TB'(op_ival_q);
		mem_we     = 1'b0;
		mem_waddr  = best_slot_q;
		mem_wdata  = {rd_per, rd_ival, alu_res};
		mem_raddr  = best_slot_q;
		out_load   = 1'b0;
		out_kind_n = dts_pkg::KIND_ACK;
		out_slot_n = '0;
		out_last_n = 1'b1;
		scan_start = 1'b0;
		unique case (state_q)
			dts_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (operation)
						dts_pkg::OP_TICK: out_load = 1'b0;
						dts_pkg::OP_ADD: begin
							out_load   = !free_v;
							out_kind_n = dts_pkg::KIND_FULL;
						end
						dts_pkg::OP_CANCEL: begin
							out_load   = 1'b1;
							out_slot_n = dts_pkg::SLOT_BITS'(slot_index);
						end
						default: out_load = 1'b1;
					endcase
				end
			end
			dts_pkg::ST_ADD_WR: begin
				alu_b      = TB'(op_ival_q);
				mem_we     = 1'b1;
				mem_waddr  = op_slot_q;
				mem_wdata  = {op_per_q, op_ival_q, alu_res};
				out_load   = 1'b1;
				out_kind_n = dts_pkg::KIND_ADDED;
				out_slot_n = dts_pkg::SLOT_BITS'(op_slot_q);
			end
			dts_pkg::ST_TICK_INC: begin
				alu_b      = TB'(1);
				scan_start = !paused_q;
			end
			dts_pkg::ST_SCAN: begin
				alu_sub   = 1'b1;
				alu_b     = rd_deadline;
				mem_raddr = scan_q;
			end
			dts_pkg::ST_BEST_RD: mem_raddr = best_slot_q;
			dts_pkg::ST_BEST_WB: begin
				alu_b  = TB'(rd_ival);
				mem_we = rd_per;
			end
			dts_pkg::ST_PUSH: begin
				out_load   = pend_v_q && out_free;
				out_kind_n = dts_pkg::KIND_FIRED;
				out_slot_n = dts_pkg::SLOT_BITS'(pend_slot_q);
				out_last_n = 1'b0;
				scan_start = push_go && !final_cnt;
			end
			dts_pkg::ST_FINAL: begin
				out_load   = out_free;
				out_kind_n = pend_v_q ? dts_pkg::KIND_FIRED : dts_pkg::KIND_NONE;
				out_slot_n = pend_v_q ? dts_pkg::SLOT_BITS'(pend_slot_q) : '0;
			end
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dts_pkg::ST_IDLE;
			now_q       <= '0;
			paused_q    <= 1'b0;
			active_q    <= '0;
			fired_q     <= '0;
			issue_q     <= 1'b0;
			scan_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			best_v_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == dts_pkg::ST_IDLE && accept) begin
				unique case (operation)
					dts_pkg::OP_CANCEL: begin
						if (cancel_ok) begin
							active_q[SW'(slot_index)] <= 1'b0;
						end
					end
					dts_pkg::OP_PAUSE: paused_q <= 1'b1;
					dts_pkg::OP_RESUME: paused_q <= 1'b0;
					default: paused_q <= paused_q;
				endcase
			end
			if (state_q == dts_pkg::ST_ADD_WR) begin
				active_q[op_slot_q] <= 1'b1;
			end
			if (state_q == dts_pkg::ST_TICK_INC) begin
				now_q    <= alu_res;
				fired_q  <= '0;
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
			end
			if (scan_start) begin
				issue_q  <= 1'b1;
				scan_q   <= '0;
				best_v_q <= 1'b0;
			end else if (state_q == dts_pkg::ST_SCAN && issue_q) begin
				if (scan_q == LAST_SLOT) begin
					issue_q <= 1'b0;
				end else begin
					scan_q <= scan_q + SW'(1);
				end
			end
			v_s1 <= (state_q == dts_pkg::ST_SCAN) && issue_q;
			v_s2 <= v_s1;
			if (upd) begin
				best_v_q <= 1'b1;
			end
			if (state_q == dts_pkg::ST_BEST_WB) begin
				fired_q[best_slot_q] <= 1'b1;
				if (!rd_per) begin
					active_q[best_slot_q] <= 1'b0;
				end
			end
			if (state_q == dts_pkg::ST_PUSH && push_go) begin
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + FCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dts_pkg::ST_IDLE && accept) begin
			op_slot_q <= free_idx;
			op_ival_q <= in_ival;
			op_per_q  <= periodic;
		end
		slot_s1 <= scan_q;
		last_s1 <= scan_q == LAST_SLOT;
		slot_s2 <= slot_s1;
		last_s2 <= last_s1;
		late_s2 <= alu_res;
		elig_s2 <= active_q[slot_s1] && !fired_q[slot_s1] && !alu_res[TB-1];
		if (upd) begin
			best_slot_q <= slot_s2;
			best_late_q <= late_s2;
		end
		if (state_q == dts_pkg::ST_PUSH && push_go) begin
			pend_slot_q <= best_slot_q;
		end
		if (out_load) begin
			kind_q <= out_kind_n;
			slot_q <= out_slot_n;
			last_q <= out_last_n;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign slot      = slot_q;
	assign last      = last_q;

	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FCW'(dts_pkg::MAX_FIRES))
		else $error("fire count passed its limit");

	a_best_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dts_pkg::ST_BEST_RD |-> active_q[best_slot_q] && !fired_q[best_slot_q])
		else $error("chosen slot is not an active unfired slot");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == dts_pkg::KIND_NONE |-> last_q)
		else $error("empty tick word without last mark");

	a_pause_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(paused_q) |-> $past(accept && operation == dts_pkg::OP_PAUSE))
		else $error("pause set without a pause word");

endmodule
